>>> rtl/assert_macros.svh
// Assertion macros used by the route select datapath.
// Needs nothing else; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every edge outside reset.
`define WTRS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define WTRS_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define WTRS_ASSERT(lbl, clk, rst_n, prop, msg)

`define WTRS_ASSERT_NR(lbl, clk, prop, msg)

`endif

`endif

>>> rtl/wtrs_pkg.sv
// Types and constants for the weighted table route select block.
// Used by the controller, the datapath and the top level.
`default_nettype none

package wtrs_pkg;

  localparam int OP_W       = 2;
  localparam int VNET_W     = 2;
  localparam int LINK_W     = 4;
  localparam int DEST_W     = 64;
  localparam int WEIGHT_W   = 16;
  localparam int TIE_W      = 5;
  localparam int LCNT_W     = 5;
  localparam int ORD_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int LFSR_W     = 16;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'h0001;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP       = 2'd0,
    OP_WRITE_MASK   = 2'd1,
    OP_WRITE_WEIGHT = 2'd2,
    OP_NONE         = 2'd3
  } wtrs_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINK_COUNT   = 2'd0,
    CFG_ORDERED_MASK = 2'd1
  } wtrs_cfg_idx_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DIV_GO,
    S_DIV,
    S_PICK,
    S_DONE
  } wtrs_state_t;

  typedef struct packed {
    logic clear_en;
    logic accept;
    logic scan_en;
    logic mod_start;
    logic pick_load;
    logic pick_en;
    logic out_load;
  } wtrs_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic scan_done;
    logic found;
    logic ordered;
    logic mod_done;
    logic pick_done;
    logic out_busy;
  } wtrs_sts_t;

endpackage

`default_nettype wire

>>> rtl/wtrs_mod.sv
// Restoring remainder unit: LFSR value modulo the tie count, one bit a cycle.
// Depends on wtrs_pkg.
`default_nettype none

module wtrs_mod #(
  parameter int DW = 5
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [wtrs_pkg::LFSR_W-1:0] dividend,
  input  wire logic [DW-1:0]              divisor,
  output logic      [DW-1:0]              rem,
  output logic                            done
);
  import wtrs_pkg::*;

  localparam int CNT_W = $clog2(LFSR_W);

  logic [LFSR_W-1:0] dvd_r;
  logic [DW-1:0]     div_r;
  logic [DW-1:0]     rem_r;
  logic [DW-1:0]     rem_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DW:0]       shifted;
  logic [DW:0]       diff;

  always_comb begin
    shifted = {rem_r, dvd_r[LFSR_W-1]};
    diff    = shifted - {1'b0, div_r};
    // partial remainder stays below the divisor, so DW bits hold it
    rem_nxt = (shifted >= {1'b0, div_r}) ? diff[DW-1:0] : shifted[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(LFSR_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[LFSR_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign rem  = rem_r;
  assign done = done_r;

endmodule

`default_nettype wire

>>> rtl/wtrs_dpath.sv
// Datapath: route and weight memories, scan registers, LFSR, pick walk,
// config registers and the result register. Depends on wtrs_pkg, wtrs_mod.
`default_nettype none

`include "assert_macros.svh"

module wtrs_dpath #(
  parameter int LINKS     = 16,
  parameter int VNETS     = 4,
  parameter int DEST_BITS = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire wtrs_pkg::wtrs_cmd_t            cmd,
  output wtrs_pkg::wtrs_sts_t                 sts,
  input  wire logic                           cfg_valid,
  input  wire logic [wtrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [wtrs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic [wtrs_pkg::OP_W-1:0]       in_operation,
  input  wire logic [wtrs_pkg::VNET_W-1:0]     in_vnet,
  input  wire logic [wtrs_pkg::LINK_W-1:0]     in_link,
  input  wire logic [wtrs_pkg::DEST_W-1:0]     in_dest_mask,
  input  wire logic [wtrs_pkg::WEIGHT_W-1:0]   in_weight,
  input  wire logic                           out_ready,
  output logic                                out_valid,
  output logic      [wtrs_pkg::LINK_W-1:0]     out_link,
  output logic                                out_no_route,
  output logic      [wtrs_pkg::TIE_W-1:0]      out_tie_count
);
  import wtrs_pkg::*;

  localparam int DEPTH = VNETS * LINKS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW    = (LINKS > 1) ? $clog2(LINKS) : 1;
  localparam int CW    = $clog2(LINKS + 1);

  // config
  logic [LCNT_W-1:0] link_count_r;
  logic [ORD_W-1:0]  ordered_r;

  // memories
  logic [DEST_BITS-1:0] route_mem [DEPTH];
  logic [WEIGHT_W-1:0]  weight_mem [LINKS];

  logic [AW-1:0]        clr_addr_r;
  logic                 rwr_en;
  logic [AW-1:0]        rwr_addr;
  logic [DEST_BITS-1:0] rwr_data;
  logic                 wwr_en;
  logic [LW-1:0]        wwr_addr;
  logic [WEIGHT_W-1:0]  wwr_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [DEST_BITS-1:0] mem_q_r;
  logic [WEIGHT_W-1:0]  wq_r;

  // lookup item
  logic [VNET_W-1:0]    vnet_r;
  logic [DEST_BITS-1:0] dest_r;
  logic [CW-1:0]        used_r;
  logic [CW-1:0]        used_nxt;
  logic                 vnet_ok;
  logic                 link_ok;
  logic [AW-1:0]        in_addr;

  // scan
  logic [CW-1:0]        iss_r;
  logic                 q_vld_r;
  logic [LW-1:0]        q_idx_r;
  logic                 found_r;
  logic [WEIGHT_W-1:0]  minw_r;
  logic [CW-1:0]        ties_r;
  logic [LINKS-1:0]     cand_r;
  logic                 hit;
  logic [LINKS-1:0]     q_onehot;

  // pick
  logic [LFSR_W-1:0]    lfsr_r;
  logic [CW-1:0]        pick_r;
  logic [CW-1:0]        seen_r;
  logic [LW-1:0]        pi_r;
  logic [LW-1:0]        sel_r;
  logic                 pick_hit;
  logic [CW-1:0]        mod_rem;
  logic                 mod_done;
  logic [6:0]           sel_wide;
  logic [6:0]           ties_wide;

  // result register
  logic                 out_valid_r;
  logic [LINK_W-1:0]    out_link_r;
  logic                 out_no_route_r;
  logic [TIE_W-1:0]     out_tie_r;

  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] s);
    logic fb;
    fb = s[0] ^ s[2] ^ s[3] ^ s[5];
    return {fb, s[LFSR_W-1:1]};
  endfunction

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_count_r <= '0;
      ordered_r    <= '0;
    end else if (cfg_valid) begin
      case (wtrs_cfg_idx_t'(cfg_index))
        CFG_LINK_COUNT:   link_count_r <= cfg_data[LCNT_W-1:0];
        CFG_ORDERED_MASK: ordered_r    <= cfg_data[ORD_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- memory ports
  always_comb begin
    vnet_ok  = 32'(in_vnet) < VNETS;
    link_ok  = 32'(in_link) < LINKS;
    in_addr  = AW'(32'(in_vnet) * LINKS + 32'(in_link));
    used_nxt = (32'(link_count_r) > LINKS) ? CW'(LINKS) : CW'(link_count_r);

    rwr_en   = 1'b0;
    rwr_addr = in_addr;
    rwr_data = in_dest_mask[DEST_BITS-1:0];
    wwr_en   = 1'b0;
    wwr_addr = LW'(in_link);
    wwr_data = in_weight;
    if (cmd.clear_en) begin
      rwr_en   = 1'b1;
      rwr_addr = clr_addr_r;
      rwr_data = '0;
      wwr_en   = 32'(clr_addr_r) < LINKS;
      wwr_addr = LW'(clr_addr_r);
      wwr_data = '0;
    end else if (cmd.accept) begin
      rwr_en = (wtrs_op_t'(in_operation) == OP_WRITE_MASK) && vnet_ok && link_ok;
      wwr_en = (wtrs_op_t'(in_operation) == OP_WRITE_WEIGHT) && link_ok;
    end

    rd_en   = cmd.scan_en && (iss_r < used_r);
    rd_addr = AW'(32'(vnet_r) * LINKS + 32'(iss_r));
  end

  always_ff @(posedge clk) begin
    if (rwr_en) route_mem[rwr_addr] <= rwr_data;
    if (rd_en)  mem_q_r <= route_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wwr_en) weight_mem[wwr_addr] <= wwr_data;
    if (rd_en)  wq_r <= weight_mem[LW'(iss_r)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_addr_r <= '0;
    else if (cmd.clear_en) clr_addr_r <= clr_addr_r + 1'b1;
  end

  // ---------------------------------------------------------------- scan
  always_comb begin
    hit      = q_vld_r && (|(mem_q_r & dest_r));
    q_onehot = LINKS'(1) << q_idx_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      vnet_r <= in_vnet;
      dest_r <= in_dest_mask[DEST_BITS-1:0];
      // an out of range vnet scans nothing and ends in no route
      used_r <= vnet_ok ? used_nxt : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r   <= '0;
      q_vld_r <= 1'b0;
      found_r <= 1'b0;
      ties_r  <= '0;
      cand_r  <= '0;
    end else if (cmd.accept) begin
      iss_r   <= '0;
      q_vld_r <= 1'b0;
      found_r <= 1'b0;
      ties_r  <= '0;
      cand_r  <= '0;
    end else begin
      q_vld_r <= rd_en;
      if (rd_en) iss_r <= iss_r + 1'b1;
      if (hit) begin
        found_r <= 1'b1;
        if (!found_r || (wq_r < minw_r)) begin
          ties_r <= CW'(1);
          cand_r <= q_onehot;
        end else if (wq_r == minw_r) begin
          ties_r <= ties_r + 1'b1;
          cand_r <= cand_r | q_onehot;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) q_idx_r <= LW'(iss_r);
    if (hit && (!found_r || (wq_r < minw_r))) minw_r <= wq_r;
  end

  // ---------------------------------------------------------------- pick
  wtrs_mod #(
    .DW (CW)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.mod_start),
    .dividend (lfsr_r),
    .divisor  (ties_r),
    .rem      (mod_rem),
    .done     (mod_done)
  );

  assign pick_hit = cmd.pick_en && cand_r[pi_r] && (seen_r == pick_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= LFSR_SEED;
    end else if (cmd.pick_load && !ordered_r[vnet_r]) begin
      lfsr_r <= lfsr_next(lfsr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pick_load) begin
      pick_r <= ordered_r[vnet_r] ? '0 : mod_rem;
      seen_r <= '0;
      pi_r   <= '0;
    end else if (cmd.pick_en) begin
      pi_r <= pi_r + 1'b1;
      if (cand_r[pi_r] && (seen_r != pick_r)) seen_r <= seen_r + 1'b1;
    end
    if (pick_hit) sel_r <= pi_r;
  end

  // ---------------------------------------------------------------- result
  always_comb begin
    sel_wide  = 7'(sel_r);
    ties_wide = 7'(ties_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_link_r     <= found_r ? sel_wide[LINK_W-1:0] : '0;
      out_no_route_r <= !found_r;
      out_tie_r      <= found_r ? ties_wide[TIE_W-1:0] : '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_link      = out_link_r;
  assign out_no_route  = out_no_route_r;
  assign out_tie_count = out_tie_r;

  // status is only looked at in the state that owns it
  always_comb begin
    sts.clear_last = clr_addr_r == AW'(DEPTH - 1);
    sts.scan_done  = (iss_r == used_r) && !q_vld_r;
    sts.found      = found_r;
    sts.ordered    = ordered_r[vnet_r];
    sts.mod_done   = mod_done;
    sts.pick_done  = cand_r[pi_r] && (seen_r == pick_r);
    sts.out_busy   = out_valid_r && !out_ready;
  end

  `WTRS_ASSERT(a_lfsr_nonzero, clk, rst_n, lfsr_r != '0, "LFSR reached zero")
  `WTRS_ASSERT(a_found_has_ties, clk, rst_n, found_r |-> (ties_r != '0), "found with no ties")
  `WTRS_ASSERT(a_load_not_busy, clk, rst_n, cmd.out_load |-> !sts.out_busy, "load over held item")
  `WTRS_ASSERT_NR(a_reset_clears_out, clk, !rst_n |=> !out_valid_r, "result valid after reset")

endmodule

`default_nettype wire

>>> rtl/wtrs_ctrl.sv
// Controller state machine: clearing pass, item accept, scan, divide,
// pick walk and result hand-off. Depends on wtrs_pkg.
`default_nettype none

module wtrs_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  input  wire logic [wtrs_pkg::OP_W-1:0] in_operation,
  output logic                          in_ready,
  output wtrs_pkg::wtrs_cmd_t           cmd,
  input  wire wtrs_pkg::wtrs_sts_t      sts
);
  import wtrs_pkg::*;

  wtrs_state_t state_r;
  wtrs_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (sts.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && (wtrs_op_t'(in_operation) == OP_LOOKUP)) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          if (!sts.found)      state_nxt = S_DONE;
          else if (sts.ordered) state_nxt = S_PICK;
          else                 state_nxt = S_DIV_GO;
        end
      end
      S_DIV_GO: state_nxt = S_DIV;
      S_DIV: begin
        if (sts.mod_done) state_nxt = S_PICK;
      end
      S_PICK: begin
        if (sts.pick_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_CLEAR: cmd.clear_en = 1'b1;
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_SCAN: begin
        cmd.scan_en   = 1'b1;
        cmd.pick_load = sts.scan_done && sts.found && sts.ordered;
      end
      S_DIV_GO: cmd.mod_start = 1'b1;
      S_DIV:    cmd.pick_load = sts.mod_done;
      S_PICK:   cmd.pick_en   = 1'b1;
      S_DONE:   cmd.out_load  = !sts.out_busy;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/weighted_table_route_select.sv
// Weighted table route select: route table writes and min-weight lookups.
// Depends on wtrs_pkg, wtrs_ctrl, wtrs_dpath (and wtrs_mod below it).
//
// After reset the block clears its route and weight memories, one entry a
// cycle, all VNETS*LINKS route entries (64 at the defaults); in_ready stays
// low meanwhile, config writes are taken at any time. Mask and weight writes
// are done at acceptance, so in_ready stays high across them. A lookup reads
// the route and weight memories one link a cycle through their single read
// port for the scan, then for unordered vnets a remainder step (16 bits, one
// a cycle), then a walk over the candidate set to the chosen link, then the
// result is loaded into the result register, and in_ready is high again
// while it is shown. The result register lets the next item be taken while
// a result waits; a later lookup holds its result back until the earlier
// one is taken.
`default_nettype none

module weighted_table_route_select #(
  parameter int LINKS     = 16,
  parameter int VNETS     = 4,
  parameter int DEST_BITS = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [wtrs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [wtrs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [wtrs_pkg::OP_W-1:0]        in_operation,
  input  wire logic [wtrs_pkg::VNET_W-1:0]      in_vnet,
  input  wire logic [wtrs_pkg::LINK_W-1:0]      in_link,
  input  wire logic [wtrs_pkg::DEST_W-1:0]      in_dest_mask,
  input  wire logic [wtrs_pkg::WEIGHT_W-1:0]    in_weight,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [wtrs_pkg::LINK_W-1:0]      out_link,
  output logic                                 out_no_route,
  output logic      [wtrs_pkg::TIE_W-1:0]       out_tie_count
);
  import wtrs_pkg::*;

  wtrs_cmd_t cmd;
  wtrs_sts_t sts;

  assign cfg_ready = 1'b1;

  wtrs_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .sts          (sts)
  );

  wtrs_dpath #(
    .LINKS     (LINKS),
    .VNETS     (VNETS),
    .DEST_BITS (DEST_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_operation  (in_operation),
    .in_vnet       (in_vnet),
    .in_link       (in_link),
    .in_dest_mask  (in_dest_mask),
    .in_weight     (in_weight),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_link      (out_link),
    .out_no_route  (out_no_route),
    .out_tie_count (out_tie_count)
  );

endmodule

`default_nettype wire
